@@ src/sli_pkg.sv @@
package sli_pkg;

    // Number of cells in the list.
    localparam int CAPACITY = 16;

    // Width of the entry counter, wide enough to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of a cell index.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [4:0]         entry_count;
        logic signed [31:0] smallest;
    } t_result;

    // Per-cell control supplied by the top level.
    typedef struct packed {
        logic occ;     // The cell holds a valid entry.
        logic ins_en;  // An insert transaction is being committed.
        logic rem_en;  // A remove transaction with a match is being committed.
    } t_cell_ctl;

endpackage

@@ src/sli_cell.sv @@
module sli_cell
    import sli_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_left_entry,
    input  logic               i_left_take,
    input  logic signed [31:0] i_right_entry,
    output logic signed [31:0] o_entry,
    output logic               o_take,
    output logic               o_match
);

    logic signed [31:0] r_entry;
    logic               w_lt;
    logic               w_gt;
    logic               w_shift;

    // The list is ascending, so the take and shift flags are monotone along the row.
    assign w_lt    = r_entry < i_value;
    assign w_gt    = i_value < r_entry;
    assign o_take  = !i_ctl.occ || w_gt;
    assign w_shift = !(i_ctl.occ && w_lt);
    assign o_match = i_ctl.occ && (r_entry == i_value);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && o_take) begin
            r_entry <= i_left_take ? i_left_entry : i_value;
        end else if (i_ctl.rem_en && w_shift) begin
            r_entry <= i_right_entry;
        end
    end

endmodule

@@ src/sorted_list_insert_remove.sv @@
// Sorted list of up to CAPACITY signed 32-bit values held in a row of
// compare-and-shift cells. A transaction is accepted at any rising edge at
// which i_start is high and o_busy is low. o_busy is high only while reset
// is held, so once reset is released a new transaction may be given in
// every cycle. For each transaction the cells compare the
// value with their entries in parallel and shift in the same edge, and the
// result appears on o_result with o_done high during the following cycle
// only. The receiver cannot stall, so it must take the result in that
// cycle. Inserting places the value after any equal entries; removing
// deletes one entry equal to the value. Entries above the count are never
// read, so the cells need no clearing after reset.
module sorted_list_insert_remove
    import sli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    logic signed [31:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_take;
    logic [CAPACITY-1:0] w_match;
    t_cell_ctl           w_ctl [CAPACITY];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_status          r_status;
    t_status          n_status;

    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_found;
    logic w_ins_en;
    logic w_rem_en;

    // The list refuses transactions only while reset is held.
    assign o_busy   = !i_rst_n;
    assign w_accept = i_start && !o_busy;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_found = |w_match;

    // Commit enables: an insert into a full list and a remove without a match
    // leave the cells untouched.
    assign w_ins_en = w_accept && (i_cmd.op == OP_INSERT) && !w_full;
    assign w_rem_en = w_accept && (i_cmd.op == OP_REMOVE) && w_found;

    // The row of cells. Each cell takes its left neighbour's entry when an
    // insert opens a gap and its right neighbour's entry when a remove closes one.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_ctl[g].occ    = (CNT_W'(g) < r_count);
        assign w_ctl[g].ins_en = w_ins_en;
        assign w_ctl[g].rem_en = w_rem_en;

        if (g == 0) begin : g_first
            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl[g]),
                .i_value       (i_cmd.value),
                .i_left_entry  (i_cmd.value),
                .i_left_take   (1'b0),
                .i_right_entry ((CAPACITY > 1) ? w_entry[IDX_W'(g + 1)] : w_entry[g]),
                .o_entry       (w_entry[g]),
                .o_take        (w_take[g]),
                .o_match       (w_match[g])
            );
        end else if (g == CAPACITY - 1) begin : g_last
            // The last cell refills from itself; that slot falls outside the count.
            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl[g]),
                .i_value       (i_cmd.value),
                .i_left_entry  (w_entry[g - 1]),
                .i_left_take   (w_take[g - 1]),
                .i_right_entry (w_entry[g]),
                .o_entry       (w_entry[g]),
                .o_take        (w_take[g]),
                .o_match       (w_match[g])
            );
        end else begin : g_mid
            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl[g]),
                .i_value       (i_cmd.value),
                .i_left_entry  (w_entry[g - 1]),
                .i_left_take   (w_take[g - 1]),
                .i_right_entry (w_entry[g + 1]),
                .o_entry       (w_entry[g]),
                .o_take        (w_take[g]),
                .o_match       (w_match[g])
            );
        end
    end

    // Status and new count of the transaction being accepted.
    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        if (i_cmd.op == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else if (!w_found) begin
                n_status = ST_NOTFOUND;
            end else begin
                n_status = ST_REMOVED;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    // The smallest entry is read straight from the cells, which already hold the new
    // contents during the cycle in which o_done is high.
    assign o_done               = r_done;
    assign o_result.status      = r_status;
    assign o_result.entry_count = 5'(r_count);
    assign o_result.smallest    = w_empty ? 32'sd0 : w_entry[0];

endmodule
